/* rtl/core/pif_pkg.sv */
// pif_pkg: shared constants and types for the printf integer formatter
// used by pif_ctrl, pif_dp and printf_integer_formatter
package pif_pkg;
    localparam int MAX_FIELD = 60;
    localparam int OUT_CAP   = 62;

    // reciprocal of ten scaled by 2^22, exact for the dividends used here (below 655360)
    localparam logic [18:0] RECIP10 = 19'd419431;

    localparam logic [2:0] CONV_D  = 3'd0;
    localparam logic [2:0] CONV_O  = 3'd1;
    localparam logic [2:0] CONV_U  = 3'd2;
    localparam logic [2:0] CONV_XL = 3'd3;
    localparam logic [2:0] CONV_XU = 3'd4;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_H    = 2'd1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic plan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic       valid_conv;
        logic       div_done;
        logic       emit_last;
    } t_status;
endpackage

/* rtl/core/pif_dp.sv */
// pif_dp: datapath, value preparation, digit extraction and character emission
// depends on pif_pkg
module pif_dp import pif_pkg::*; (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_arg_bits,
    input  logic [2:0]  i_conversion,
    input  logic [1:0]  i_length_mod,
    input  logic        i_left_justify,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_pad,
    input  logic [5:0]  i_field_width,
    input  logic signed [6:0] i_min_digits,
    output t_status     o_status,
    output logic [7:0]  o_char,
    output logic        o_total_zero
);
    logic [63:0] r_mag;
    logic [2:0]  r_conv;
    logic        r_left, r_plus, r_space, r_alt, r_zpad, r_given, r_neg, r_nz;
    logic [5:0]  r_width, r_pr;
    logic [4:0]  r_nd;
    logic [3:0]  r_dig [0:23];
    logic [1:0]  r_sub;
    logic [47:0] r_quo;
    logic [3:0]  r_rem;
    logic [4:0]  r_base;
    // field plan
    logic [6:0]  r_pad_lo, r_sign_end, r_pfx_end, r_zero_end, r_dig_end, r_total;
    logic [6:0]  r_pos;
    logic [7:0]  r_sign_ch;

    logic [63:0] mask, val;
    logic [63:0] neg_val;
    logic        neg_in;
    logic [5:0]  pr_in;
    logic        given_in;
    logic [6:0]  count, body, body2, count2, pad, sgn_n, pfx_n;

    always_comb begin
        unique case (i_length_mod)
            LEN_H:    mask = 64'hFFFF;
            LEN_NONE: mask = 64'hFFFF_FFFF;
            default:  mask = '1;
        endcase
        val = i_arg_bits & mask;
        neg_val = (~val + 64'd1) & mask;
        neg_in = (i_conversion == CONV_D) && |(val & ((mask >> 1) + 64'd1));
        given_in = ~i_min_digits[6];
        pr_in = given_in ? ((i_min_digits[5:0] > 6'(MAX_FIELD)) ? 6'(MAX_FIELD)
                 : i_min_digits[5:0]) : 6'd1;
    end

    // decimal: 16-bit chunks, msb first, four chunk steps per digit via reciprocal
    // multiplication; octal and hex: one digit per cycle by shifting
    logic [19:0] dec_v;
    logic [38:0] dec_prod;
    logic [15:0] dec_q;
    logic [19:0] dec_q10;
    logic [3:0]  dec_r;
    logic        dec_mode;
    logic [3:0]  step_dig;
    logic [63:0] step_mag;
    always_comb begin
        dec_v = {r_rem, r_mag[63:48]};
        dec_prod = 39'(dec_v) * 39'(RECIP10);
        dec_q = dec_prod[37:22];
        dec_q10 = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0};
        dec_r = 4'(dec_v - dec_q10);
        dec_mode = (r_base == 5'd10);
        if (r_base == 5'd8) begin
            step_dig = {1'b0, r_mag[2:0]};
            step_mag = {3'b000, r_mag[63:3]};
        end else begin
            step_dig = r_mag[3:0];
            step_mag = {4'b0000, r_mag[63:4]};
        end
    end

    always_comb begin
        count = (r_pr > 6'(r_nd)) ? 7'(r_pr) : 7'(r_nd);
        if (r_conv == CONV_O && r_alt && count == 7'(r_nd)) count = count + 7'd1;
        sgn_n = (r_conv == CONV_D && (r_neg || r_plus || r_space)) ? 7'd1 : 7'd0;
        pfx_n = (r_conv >= CONV_XL && r_alt && r_nz) ? 7'd2 : 7'd0;
        body = sgn_n + pfx_n + count;
        count2 = count;
        body2 = body;
        if (r_zpad && !r_left && !r_given && 7'(r_width) > body) begin
            count2 = count + (7'(r_width) - body);
            body2 = 7'(r_width);
        end
        pad = (7'(r_width) > body2) ? 7'(r_width) - body2 : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_conv  <= i_conversion;
            r_left  <= i_left_justify;
            r_plus  <= i_force_plus;
            r_space <= i_space_sign;
            r_alt   <= i_alt_form;
            r_zpad  <= i_zero_pad;
            r_given <= given_in;
            r_pr    <= pr_in;
            r_width <= (i_field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_field_width;
            r_nz    <= val != 64'd0;
            r_neg   <= neg_in;
            r_mag   <= neg_in ? neg_val : val;
            r_base <= (i_conversion == CONV_O) ? 5'd8 :
                      ((i_conversion >= CONV_XL) ? 5'd16 : 5'd10);
            r_nd  <= '0;
            r_sub <= '0;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (dec_mode) begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    r_dig[r_nd] <= dec_r;
                    r_nd  <= r_nd + 5'd1;
                    r_mag <= {r_quo, dec_q};
                    r_quo <= '0;
                    r_rem <= '0;
                end else begin
                    r_mag <= {r_mag[47:0], 16'h0000};
                    r_quo <= {r_quo[31:0], dec_q};
                    r_rem <= dec_r;
                end
            end else begin
                r_dig[r_nd] <= step_dig;
                r_nd  <= r_nd + 5'd1;
                r_mag <= step_mag;
            end
        end else if (i_cmd.plan) begin
            r_pad_lo   <= r_left ? 7'd0 : pad;
            r_sign_end <= (r_left ? 7'd0 : pad) + sgn_n;
            r_pfx_end  <= (r_left ? 7'd0 : pad) + sgn_n + pfx_n;
            r_zero_end <= (r_left ? 7'd0 : pad) + sgn_n + pfx_n + (count2 - 7'(r_nd));
            r_dig_end  <= (r_left ? 7'd0 : pad) + body2;
            r_total    <= ((body2 + pad) > 7'(OUT_CAP)) ? 7'(OUT_CAP) : body2 + pad;
            r_sign_ch  <= r_neg ? 8'h2D : (r_plus ? 8'h2B : 8'h20);
            r_pos      <= '0;
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 7'd1;
        end
    end

    logic [6:0] didx_w;
    logic [4:0] didx;
    logic [3:0] dv;
    always_comb begin
        didx_w = r_dig_end - 7'd1 - r_pos;
        didx = didx_w[4:0];
        dv = r_dig[didx];
        if (r_pos < r_pad_lo) o_char = 8'h20;
        else if (r_pos < r_sign_end) o_char = r_sign_ch;
        else if (r_pos < r_pfx_end)
            o_char = (r_pos == r_pfx_end - 7'd2) ? 8'h30 :
                     ((r_conv == CONV_XL) ? 8'h78 : 8'h58);
        else if (r_pos < r_zero_end) o_char = 8'h30;
        else if (r_pos < r_dig_end)
            o_char = (dv < 4'd10) ? 8'h30 + 8'(dv) :
                     8'h41 + 8'(dv - 4'd10) + ((r_conv == CONV_XL) ? 8'd32 : 8'd0);
        else o_char = 8'h20;
    end

    always_comb begin
        o_status.valid_conv = i_conversion <= CONV_XU;
        o_status.div_done   = (r_sub == 2'd0) && (r_mag == 64'd0 || r_nd == 5'd24);
        o_status.emit_last  = (r_pos + 7'd1 >= r_total);
    end

    // empty field, valid from the cycle after the plan
    assign o_total_zero = (r_total == 7'd0);
endmodule

/* rtl/core/pif_ctrl.sv */
// pif_ctrl: sequencing state machine for the formatter
// depends on pif_pkg
module pif_ctrl import pif_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    input  logic    i_empty,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output logic    o_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PLAN = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_valid = 1'b0;
        o_last = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_start && i_status.valid_conv) begin
                o_cmd.load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_PLAN;
                else o_cmd.div_step = 1'b1;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: n_state = i_empty ? S_IDLE : S_EMIT;
            S_EMIT: begin
                o_valid = 1'b1;
                o_cmd.emit = 1'b1;
                o_last = i_status.emit_last;
                if (i_status.emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = r_state != S_IDLE;
endmodule

/* rtl/core/printf_integer_formatter.sv */
// printf_integer_formatter: top level, one printf integer conversion per transaction
// depends on pif_pkg, pif_ctrl, pif_dp
//
// channel   direction  handshake              payload
// command   in         i_start && !o_busy     argument, conversion, flags, width, precision
// result    out        o_char_valid strobe    o_out_char, o_last_char
//
// one transaction: load at the accepting edge, then digit extraction (decimal by
// reciprocal multiplication, octal and hex by shifting) until done is seen, then
// the plan state and the check state, then one character per cycle
// reset is synchronous, active low, and returns the sequencer to idle
// results are strobed for one cycle and cannot be held off
module printf_integer_formatter import pif_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_arg_bits,
    input  logic [2:0]  i_conversion,
    input  logic [1:0]  i_length_mod,
    input  logic        i_left_justify,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_pad,
    input  logic [5:0]  i_field_width,
    input  logic signed [6:0] i_min_digits,
    output logic        o_char_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);
    t_cmd    cmd;
    t_status status;
    logic    last;

    // empty field: plan yields zero characters, checked in a dedicated check state
    logic emp_w;

    pif_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_status(status),
        .i_empty(emp_w), .o_cmd(cmd), .o_busy(o_busy), .o_valid(o_char_valid),
        .o_last(last)
    );

    pif_dp u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_arg_bits(i_arg_bits),
        .i_conversion(i_conversion), .i_length_mod(i_length_mod),
        .i_left_justify(i_left_justify), .i_force_plus(i_force_plus),
        .i_space_sign(i_space_sign), .i_alt_form(i_alt_form),
        .i_zero_pad(i_zero_pad), .i_field_width(i_field_width),
        .i_min_digits(i_min_digits), .o_status(status), .o_char(o_out_char),
        .o_total_zero(emp_w)
    );

    assign o_last_char = last;
endmodule

/* rtl/core/pif_checker.sv */
// pif_checker: port-level assertions for printf_integer_formatter
// depends on printf_integer_formatter ports
module pif_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_char_valid,
    input logic o_last_char
);
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> o_char_valid) else $error("last without strobe");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> o_busy) else $error("strobe while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |=> !o_char_valid) else $error("strobe after last");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_start && !o_busy) |=> !o_busy) else $error("busy without start");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy) else $error("busy after reset");
endmodule

bind printf_integer_formatter pif_checker u_pif_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_char_valid(o_char_valid), .o_last_char(o_last_char)
);

/* tb/printf_integer_formatter_test.sv */
// printf_integer_formatter_test: self-checking bench for the printf integer formatter
// depends on pif_pkg and printf_integer_formatter; holds the formatter predictor and scoreboard
`timescale 1ns / 1ps

module printf_integer_formatter_test;
    import pif_pkg::*;

    // one expected character of a formatted field
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char;

    // predicts the characters of each conversion and checks the strobed output
    class field_scoreboard;
        t_char pending[$];
        int    mismatches;

        // works out the characters one conversion should produce
        function void note_conversion(logic [63:0] arg, logic [2:0] conv, logic [1:0] lenm,
                                      bit left, bit plus, bit spc, bit alt, bit zpad,
                                      logic [5:0] wraw, logic [6:0] praw);
            logic [63:0] msk;
            logic [63:0] val;
            logic [63:0] mag;
            logic [7:0]  dig[24];
            logic [7:0]  line[$];
            logic [7:0]  sgn;
            bit          neg;
            bit          given;
            bit          pfx;
            int          pr;
            int          wd;
            int          base;
            int          nd;
            int          cnt;
            int          body;
            int          pad;
            int          d;
            int          n;
            t_char       c;
            if (conv > CONV_XU) return;
            msk = (lenm == LEN_H) ? 64'hFFFF : (lenm == LEN_NONE) ? 64'hFFFF_FFFF : '1;
            val = arg & msk;
            mag = val;
            neg = 0;
            if (conv == CONV_D && (val & ((msk >> 1) + 1)) != 0) begin
                neg = 1;
                mag = (~val + 1) & msk;
            end
            given = !praw[6];
            pr = given ? int'(praw) : 1;
            if (pr > MAX_FIELD) pr = MAX_FIELD;
            wd = (wraw > MAX_FIELD) ? MAX_FIELD : int'(wraw);
            base = (conv == CONV_O) ? 8 : (conv >= CONV_XL) ? 16 : 10;
            nd = 0;
            while (mag != 0) begin
                d = int'(mag % base);
                if (d < 10) dig[nd] = 8'(8'h30 + d);
                else dig[nd] = 8'(8'h41 + (d - 10) + ((conv == CONV_XL) ? 32 : 0));
                nd++;
                mag = mag / base;
            end
            cnt = (pr > nd) ? pr : nd;
            if (conv == CONV_O && alt && cnt == nd) cnt++;
            sgn = 0;
            if (conv == CONV_D) begin
                if (neg) sgn = "-";
                else if (plus) sgn = "+";
                else if (spc) sgn = " ";
            end
            pfx = (conv >= CONV_XL) && alt && (val != 0);
            body = (sgn != 0) + (pfx ? 2 : 0) + cnt;
            if (zpad && !left && !given && wd > body) begin
                cnt += wd - body;
                body = wd;
            end
            pad = (wd > body) ? wd - body : 0;
            if (!left) repeat (pad) line.push_back(" ");
            if (sgn != 0) line.push_back(sgn);
            if (pfx) begin
                line.push_back("0");
                line.push_back((conv == CONV_XL) ? "x" : "X");
            end
            repeat (cnt - nd) line.push_back("0");
            for (int i = nd; i > 0; i--) line.push_back(dig[i - 1]);
            if (left) repeat (pad) line.push_back(" ");
            n = (line.size() > OUT_CAP) ? OUT_CAP : line.size();
            for (int k = 0; k < n; k++) begin
                c.ch = line[k];
                c.last = (k + 1 == n);
                pending.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_char e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %h last %b", ch, last);
                return;
            end
            e = pending.pop_front();
            if (ch !== e.ch || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("char mismatch: expected %h/%b got %h/%b", e.ch, e.last, ch, last);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [63:0] arg_bits = 0;
    logic [2:0]  conversion = 0;
    logic [1:0]  length_mod = 0;
    logic        left_justify = 0;
    logic        force_plus = 0;
    logic        space_sign = 0;
    logic        alt_form = 0;
    logic        zero_pad = 0;
    logic [5:0]  field_width = 0;
    logic [6:0]  min_digits = 0;
    logic        char_valid;
    logic [7:0]  out_char;
    logic        last_char;

    field_scoreboard board = new();

    always #2 clk = ~clk;

    printf_integer_formatter dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_arg_bits(arg_bits), .i_conversion(conversion), .i_length_mod(length_mod),
        .i_left_justify(left_justify), .i_force_plus(force_plus), .i_space_sign(space_sign),
        .i_alt_form(alt_form), .i_zero_pad(zero_pad), .i_field_width(field_width),
        .i_min_digits(min_digits), .o_char_valid(char_valid), .o_out_char(out_char),
        .o_last_char(last_char)
    );

    // characters are strobed and cannot be held off, so check every valid cycle
    always @(posedge clk) begin
        if (rst_n && char_valid) board.check_char(out_char, last_char);
    end

    // drive one command transaction and wait until it is accepted or, if invalid, ignored
    task automatic send_conversion(logic [63:0] a, logic [2:0] cv, logic [1:0] lm,
                                   logic [4:0] flags, logic [5:0] w, logic [6:0] p);
        arg_bits = a;
        conversion = cv;
        length_mod = lm;
        {left_justify, force_plus, space_sign, alt_form, zero_pad} = flags;
        field_width = w;
        min_digits = p;
        start = 1;
        while (busy) @(negedge clk);
        @(posedge clk);
        board.note_conversion(a, cv, lm, flags[4], flags[3], flags[2], flags[1], flags[0], w, p);
        @(negedge clk);
        start = 0;
    endtask

    // random argument with a bias towards zero, small and extreme values
    function automatic logic [63:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 20));
            2: return '1;
            3: return 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // precision: half the time small, a third not given, otherwise 0 to 63
    function automatic logic [6:0] pick_prec();
        case ($urandom_range(0, 5))
            0, 1: return 7'h40 | 7'($urandom_range(0, 63));
            2: return 7'($urandom_range(0, 63));
            default: return 7'($urandom_range(0, 8));
        endcase
    endfunction

    initial begin
        int burst;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes, every conversion and the special cases
        send_conversion(0, CONV_D, LEN_NONE, 5'b00000, 0, -7'sd1);
        send_conversion(64'hFFFF_FFFF, CONV_D, LEN_NONE, 5'b00000, 0, -7'sd1);
        send_conversion(64'h8000, CONV_D, LEN_H, 5'b01000, 8, -7'sd1);
        send_conversion(64'h8000_0000_0000_0000, CONV_D, 2'd2, 5'b00001, 30, -7'sd1);
        send_conversion(64'h7FFF_FFFF_FFFF_FFFF, CONV_D, 2'd3, 5'b01100, 0, -7'sd1);
        send_conversion(42, CONV_D, LEN_NONE, 5'b00100, 6, -7'sd1);
        send_conversion(42, CONV_D, LEN_NONE, 5'b11001, 10, 7'sd4);
        send_conversion(0, CONV_D, LEN_NONE, 5'b00000, 0, 7'sd0);
        send_conversion(0, CONV_O, LEN_NONE, 5'b00010, 0, 7'sd0);
        send_conversion(0, CONV_XL, LEN_NONE, 5'b00010, 5, 7'sd0);
        send_conversion('1, CONV_O, 2'd2, 5'b00010, 0, -7'sd1);
        send_conversion(8, CONV_O, LEN_NONE, 5'b00010, 0, 7'sd5);
        send_conversion('1, CONV_U, 2'd2, 5'b01100, 63, -7'sd1);
        send_conversion(64'hDEAD_BEEF, CONV_XL, LEN_NONE, 5'b00011, 20, -7'sd1);
        send_conversion(64'hCAFE, CONV_XU, LEN_H, 5'b10010, 12, -7'sd1);
        send_conversion(64'h1234_5678_9ABC_DEF0, CONV_XU, 2'd2, 5'b00011, 63, 7'sd63);
        send_conversion(7, CONV_D, LEN_NONE, 5'b00001, 61, 7'sd61);
        send_conversion(7, CONV_D, LEN_NONE, 5'b10001, 60, 7'h40);
        send_conversion('1, 3'd5, LEN_NONE, 5'b11111, 10, 7'sd3);
        send_conversion(1, 3'd7, 2'd3, 5'b00000, 0, 7'sd0);

        // let the pipeline drain completely once before the random part
        while (board.pending.size() != 0) @(negedge clk);
        @(negedge clk);

        // random: bursts of transactions with random gaps between them
        for (int sent = 0; sent < 90; ) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++, sent++)
                send_conversion(pick_arg(), ($urandom_range(0, 15) == 0) ?
                                3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                                2'($urandom), 5'($urandom), 6'($urandom), pick_prec());
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
        end

        while (board.pending.size() != 0) @(negedge clk);
        repeat (300) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // timeout: ample time for every directed and random transaction with its gaps
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/pif_pkg.sv
rtl/core/pif_dp.sv
rtl/core/pif_ctrl.sv
rtl/core/printf_integer_formatter.sv
rtl/core/pif_checker.sv
tb/printf_integer_formatter_test.sv
